### rtl/quaternary_min_heap_top_macros.svh
// assertion macros for the heap rtl
`ifndef QUATERNARY_MIN_HEAP_TOP_MACROS_SVH
`define QUATERNARY_MIN_HEAP_TOP_MACROS_SVH

`ifndef SYNTH
// clocked check, quiet while reset is asserted
`define QMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked check that also holds through reset
`define QMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define QMH_ASSERT(lbl, prop, msg)
`define QMH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/qmh_pkg.sv
// types and constants of the 4-ary min-heap
`timescale 1ns / 1ps
package qmh_pkg;

  localparam int KEY_W  = 64;
  localparam int ITEM_W = 32;
  localparam int ENT_W  = KEY_W + ITEM_W;
  localparam int CAP_W  = 11;
  localparam int OP_W   = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // key in the upper bits, item below: one unsigned compare orders both
  typedef logic [ENT_W-1:0] entry_t;

  function automatic logic entry_before(entry_t a, entry_t b);
    return a < b;
  endfunction

endpackage

### rtl/qmh_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module qmh_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/quaternary_min_heap_top.sv
// d-ary min-heap of 64-bit keys with 32-bit item tie-break, top level
`timescale 1ns / 1ps
`include "quaternary_min_heap_top_macros.svh"
//
// usage
//   command channel: drive operation_i (push, pop, clear), key_in_i and item_in_i
//   with start high; the beat is taken at a clock edge where busy is low.
//   busy then stays high until the result has been shown.
//   result channel: exactly one result beat per command, on done_ok_o,
//   key_out_o, item_out_o and count_after_o, valid for the single cycle in
//   which result_strobe_o is high. the receiver cannot stall; it must take it.
//   capacity register: cfg_we_i writes cfg_wdata_i; only write it while idle.
// sequencing
//   clear, refused push, pop of an empty or single-entry heap, unused code:
//   result in the cycle after acceptance, next command in the cycle after that.
//   push: per parent compared a check, a parent read and a compare state, plus
//   a last check that writes the entry if it reaches the root.
//   pop: a load of the last entry, then per level a check, up to ARITY child
//   scans and a decide state, plus a last check if the moved entry reaches a
//   leaf; one read port fetches a child per cycle and one shared comparator picks the smallest.
// reset
//   the heap is empty and the capacity limit is 1024; the ram is not cleared,
//   since entries at or above the count are never used.
//
module quaternary_min_heap_top
  import qmh_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int ARITY = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [OP_W-1:0]              operation_i,
  input  logic [KEY_W-1:0]             key_in_i,
  input  logic [ITEM_W-1:0]            item_in_i,
  input  logic                         cfg_we_i,
  input  logic [CAP_W-1:0]             cfg_wdata_i,
  output logic                         result_strobe_o,
  output logic                         done_ok_o,
  output logic [KEY_W-1:0]             key_out_o,
  output logic [ITEM_W-1:0]            item_out_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_after_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int LW    = AW + $clog2(ARITY) + 1;
  localparam int JW    = $clog2(ARITY);
  // parent index by reciprocal multiply, exact for every index below 2**AW
  localparam int PSH   = AW + $clog2(ARITY);
  localparam int PW    = AW + PSH + 1;
  localparam logic [PSH:0] PMUL = (PSH+1)'(((2 ** PSH) + ARITY - 1) / ARITY);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_CHK  = 4'd1;
  localparam logic [3:0] S_UP_RD   = 4'd2;
  localparam logic [3:0] S_UP_CMP  = 4'd3;
  localparam logic [3:0] S_POP_LD  = 4'd4;
  localparam logic [3:0] S_DN_CHK  = 4'd5;
  localparam logic [3:0] S_DN_SCAN = 4'd6;
  localparam logic [3:0] S_DN_DEC  = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  // control state
  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CAP_W-1:0] cap_q;
  logic             ok_q, ok_d;
  logic             popped_q, popped_d;
  logic             first_q, first_d;

  // working registers
  entry_t           nk_q, nk_d;       // entry being moved up or down
  entry_t           best_q, best_d;   // smallest child seen so far
  entry_t           res_q, res_d;     // popped entry
  entry_t           root_q, root_d;   // copy of heap slot zero
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    parent_q, parent_d;
  logic [AW-1:0]    ch_q, ch_d;
  logic [AW-1:0]    best_idx_q, best_idx_d;
  logic [JW-1:0]    j_q, j_d;

  // ram port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [AW-1:0]    ram_raddr;
  entry_t           ram_rdata;

  // shared comparator
  entry_t           cmp_a, cmp_b;
  logic             cmp_lt;

  logic [XW-1:0]    lim_x, cap_x, cnt_x;
  logic [LW-1:0]    lo_w, cnt_w;
  logic [PW-1:0]    prod;
  logic [AW-1:0]    pos_m1;
  logic             more_kids;
  entry_t           show;

  qmh_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // effective limit is the smaller of the register and the depth
  assign cap_x = XW'(cap_q);
  assign cnt_x = XW'(cnt_q);
  assign lim_x = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;

  // first child of the current slot
  assign lo_w  = LW'(pos_q) * LW'(ARITY) + LW'(1);
  assign cnt_w = LW'(cnt_q);

  assign pos_m1 = pos_q - AW'(1);
  assign prod   = PW'(pos_m1) * PW'(PMUL);

  assign more_kids = ((CNT_W'(ch_q) + CNT_W'(1)) < cnt_q) && (j_q != JW'(ARITY - 1));

  // operand selection for the one comparator
  always_comb begin
    case (state_q)
      S_UP_CMP: begin
        cmp_a = nk_q;
        cmp_b = ram_rdata;
      end
      S_DN_SCAN: begin
        cmp_a = ram_rdata;
        cmp_b = best_q;
      end
      S_DN_DEC: begin
        cmp_a = best_q;
        cmp_b = nk_q;
      end
      default: begin
        cmp_a = nk_q;
        cmp_b = best_q;
      end
    endcase
  end

  assign cmp_lt = entry_before(cmp_a, cmp_b);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ok_d       = ok_q;
    popped_d   = popped_q;
    first_d    = first_q;
    nk_d       = nk_q;
    best_d     = best_q;
    res_d      = res_q;
    pos_d      = pos_q;
    parent_d   = parent_q;
    ch_d       = ch_q;
    best_idx_d = best_idx_q;
    j_d        = j_q;
    ram_we     = 1'b0;
    ram_waddr  = pos_q;
    ram_wdata  = nk_q;
    ram_raddr  = '0;

    case (state_q)
      S_IDLE: begin
        // prefetch the last entry for a pop
        ram_raddr = AW'(cnt_q - CNT_W'(1));
        if (start) begin
          ok_d     = 1'b0;
          popped_d = 1'b0;
          state_d  = S_FIN;
          case (operation_i)
            OP_PUSH: begin
              if (cnt_x < lim_x) begin
                nk_d    = {key_in_i, item_in_i};
                pos_d   = AW'(cnt_q);
                cnt_d   = cnt_q + CNT_W'(1);
                ok_d    = 1'b1;
                state_d = S_UP_CHK;
              end
            end
            OP_POP: begin
              if (cnt_q != '0) begin
                ok_d     = 1'b1;
                popped_d = 1'b1;
                res_d    = root_q;
                cnt_d    = cnt_q - CNT_W'(1);
                if (cnt_q != CNT_W'(1)) begin
                  state_d = S_POP_LD;
                end
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
              ok_d  = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      S_UP_CHK: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_FIN;
        end else begin
          parent_d = AW'(prod >> PSH);
          state_d  = S_UP_RD;
        end
      end
      S_UP_RD: begin
        ram_raddr = parent_q;
        state_d   = S_UP_CMP;
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          // parent moves down, keep climbing
          ram_wdata = ram_rdata;
          pos_d     = parent_q;
          state_d   = S_UP_CHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_POP_LD: begin
        nk_d    = ram_rdata;
        pos_d   = '0;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (lo_w >= cnt_w) begin
          // leaf reached
          ram_we  = 1'b1;
          state_d = S_FIN;
        end else begin
          ram_raddr = lo_w[AW-1:0];
          ch_d      = lo_w[AW-1:0];
          j_d       = '0;
          first_d   = 1'b1;
          state_d   = S_DN_SCAN;
        end
      end
      S_DN_SCAN: begin
        if (first_q || cmp_lt) begin
          best_d     = ram_rdata;
          best_idx_d = ch_q;
        end
        first_d = 1'b0;
        if (more_kids) begin
          ram_raddr = ch_q + AW'(1);
          ch_d      = ch_q + AW'(1);
          j_d       = j_q + JW'(1);
        end else begin
          state_d = S_DN_DEC;
        end
      end
      S_DN_DEC: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          // smallest child moves up, keep sinking
          ram_wdata = best_q;
          pos_d     = best_idx_q;
          state_d   = S_DN_CHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // slot zero mirrored in flops so the minimum is always at hand
  assign root_d = (ram_we && (ram_waddr == '0)) ? ram_wdata : root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      cap_q    <= CAP_RESET;
      ok_q     <= 1'b0;
      popped_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ok_q     <= ok_d;
      popped_q <= popped_d;
      first_q  <= first_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nk_q       <= nk_d;
    best_q     <= best_d;
    res_q      <= res_d;
    root_q     <= root_d;
    pos_q      <= pos_d;
    parent_q   <= parent_d;
    ch_q       <= ch_d;
    best_idx_q <= best_idx_d;
    j_q        <= j_d;
  end

  // result beat
  always_comb begin
    if (popped_q) begin
      show = res_q;
    end else if (cnt_q != '0) begin
      show = root_q;
    end else begin
      show = '0;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign result_strobe_o = (state_q == S_FIN);
  assign done_ok_o       = ok_q;
  assign key_out_o       = show[ENT_W-1:ITEM_W];
  assign item_out_o      = show[ITEM_W-1:0];
  assign count_after_o   = cnt_q;

  `QMH_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "entry count above depth")
  `QMH_ASSERT(a_cnt_only_idle, busy |=> $stable(cnt_q), "count moved during a sift")
  `QMH_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat left block idle")
  `QMH_ASSERT(a_no_idle_write, ram_we |-> busy, "heap ram written while idle")
  `QMH_ASSERT(a_climb_nonroot, (state_q == S_UP_CMP) |-> (pos_q != '0),
              "sift-up compare at the root")

endmodule

### tb/quaternary_min_heap_checker.sv
// checker for the heap: tracks command and result beats, predicts, compares
`timescale 1ns / 1ps
module quaternary_min_heap_checker
  import qmh_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int ARITY = 4,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [ITEM_W-1:0] item_i,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  input  logic              res_strobe_i,
  input  logic              res_ok_i,
  input  logic [KEY_W-1:0]  res_key_i,
  input  logic [ITEM_W-1:0] res_item_i,
  input  logic [CNT_W-1:0]  res_count_i,
  output int                mismatches_o,
  output int                outstanding_o
);

  typedef struct packed {
    logic              ok;
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item;
    logic [CNT_W-1:0]  count;
  } heap_result_t;

  entry_t           heap_mem [DEPTH];
  int unsigned      held;
  logic [CAP_W-1:0] cap_limit;
  heap_result_t     expected_q [$];
  int               mismatch_cnt;
  heap_result_t     got, want;

  // {key, item} compares as one unsigned number
  function automatic void sift_up(int unsigned pos);
    entry_t      moving;
    int unsigned parent;
    moving = heap_mem[pos];
    while (pos > 0) begin
      parent = (pos - 1) / ARITY;
      if (!(moving < heap_mem[parent])) break;
      heap_mem[pos] = heap_mem[parent];
      pos = parent;
    end
    heap_mem[pos] = moving;
  endfunction

  function automatic void sift_down(int unsigned pos);
    entry_t      moving;
    int unsigned child_lo, child_hi, best;
    moving = heap_mem[pos];
    while (1) begin
      child_lo = pos * ARITY + 1;
      if (child_lo >= held) break;
      child_hi = child_lo + ARITY;
      if (child_hi > held) child_hi = held;
      best = child_lo;
      for (int unsigned c = child_lo + 1; c < child_hi; c++)
        if (heap_mem[c] < heap_mem[best]) best = c;
      if (!(heap_mem[best] < moving)) break;
      heap_mem[pos] = heap_mem[best];
      pos = best;
    end
    heap_mem[pos] = moving;
  endfunction

  function automatic heap_result_t apply_command(logic [OP_W-1:0] op,
                                                 logic [KEY_W-1:0] key,
                                                 logic [ITEM_W-1:0] item);
    heap_result_t r;
    int unsigned  lim;
    logic         popped;
    r = '0;
    popped = 1'b0;
    lim = (cap_limit < DEPTH) ? cap_limit : DEPTH;
    case (op)
      OP_PUSH: begin
        if (held < lim) begin
          heap_mem[held] = {key, item};
          held++;
          sift_up(held - 1);
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (held > 0) begin
          {r.key, r.item} = heap_mem[0];
          popped = 1'b1;
          r.ok = 1'b1;
          held--;
          if (held > 0) begin
            heap_mem[0] = heap_mem[held];
            sift_down(0);
          end
        end
      end
      OP_CLEAR: begin
        held = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    if (!popped && held > 0) {r.key, r.item} = heap_mem[0];
    r.count = held[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      cap_limit = CAP_RESET;
      expected_q.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) cap_limit = cfg_wdata_i;
      // results first: a beat at this edge belongs to an earlier command
      if (res_strobe_i) begin
        got.ok = res_ok_i;
        got.key = res_key_i;
        got.item = res_item_i;
        got.count = res_count_i;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result ok=%0b key=%h item=%h count=%0d",
                   $time, got.ok, got.key, got.item, got.count);
          mismatch_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected ok=%0b key=%h item=%h count=%0d",
                     $time, want.ok, want.key, want.item, want.count);
            $display("%0t:                  actual ok=%0b key=%h item=%h count=%0d",
                     $time, got.ok, got.key, got.item, got.count);
            mismatch_cnt++;
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(apply_command(op_i, key_i, item_i));
      mismatches_o <= mismatch_cnt;
      outstanding_o <= expected_q.size();
    end
  end

endmodule

### tb/quaternary_min_heap_top_tb.sv
// testbench top for the 4-ary min-heap: stimulus, capacity phases and verdict
`timescale 1ns / 1ps
module quaternary_min_heap_top_tb;
  import qmh_pkg::*;

  localparam int DEPTH = 1024;
  localparam int ARITY = 4;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // code the block treats as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // longer than the longest pop, so this covers any trailing beat
  localparam int TAIL_CYCLES = 64;
  // well above the slowest legal run
  localparam int TIMEOUT_NS = 3_000_000;
  localparam int PHASE_ITEMS = 50;
  // enough pushes for a heap of five levels
  localparam int FILL_ITEMS = 100;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   operation_i;
  logic [KEY_W-1:0]  key_in_i;
  logic [ITEM_W-1:0] item_in_i;
  logic              cfg_we_i;
  logic [CAP_W-1:0]  cfg_wdata_i;
  logic              result_strobe_o;
  logic              done_ok_o;
  logic [KEY_W-1:0]  key_out_o;
  logic [ITEM_W-1:0] item_out_o;
  logic [CNT_W-1:0]  count_after_o;

  int mismatches;
  int outstanding;
  // percent chance the sender inserts an idle gap before a command beat
  int idle_pct;

  quaternary_min_heap_top #(
    .DEPTH(DEPTH),
    .ARITY(ARITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .key_in_i       (key_in_i),
    .item_in_i      (item_in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_strobe_o(result_strobe_o),
    .done_ok_o      (done_ok_o),
    .key_out_o      (key_out_o),
    .item_out_o     (item_out_o),
    .count_after_o  (count_after_o)
  );

  quaternary_min_heap_checker #(
    .DEPTH(DEPTH),
    .ARITY(ARITY)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .op_i         (operation_i),
    .key_i        (key_in_i),
    .item_i       (item_in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_strobe_i (result_strobe_o),
    .res_ok_i     (done_ok_o),
    .res_key_i    (key_out_o),
    .res_item_i   (item_out_o),
    .res_count_i  (count_after_o),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // one command beat; an optional idle gap comes first so gaps land on
  // every phase of the block's work
  task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                       input logic [ITEM_W-1:0] item);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    operation_i <= op;
    key_in_i <= key;
    item_in_i <= item;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending until every expected result beat is back and busy drops;
  // the first edge lets the checker count the last accepted beat
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    while (busy) @(posedge clk_i);
  endtask

  // capacity writes only happen with the block idle
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // keys: often from a tiny pool so ties and item tie-breaks are common,
  // plus the extremes and fully random values
  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return KEY_W'($urandom_range(7));
    if (sel == 4) return '0;
    if (sel == 5) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ITEM_W-1:0] pick_item();
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return ITEM_W'($urandom_range(3));
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // clear and the unused code stay rare so the heap can grow
  function automatic logic [OP_W-1:0] pick_op(input int push_w);
    int r;
    r = $urandom_range(99);
    if (r < 3) return OP_CLEAR;
    if (r < 6) return OP_UNUSED;
    if (r < 6 + push_w) return OP_PUSH;
    return OP_POP;
  endfunction

  task automatic random_phase(input int n, input int push_w);
    for (int i = 0; i < n; i++) begin
      // now and then the sender waits until every result is back and the block is idle
      if ($urandom_range(49) == 0) drain();
      issue(pick_op(push_w), pick_key(), pick_item());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap_sched [8];
    int               idle_sched [3];
    cap_sched = '{11'd17, 11'd3, 11'd1024, 11'd2047, 11'd1, 11'd0, 11'd40, 11'd5};
    idle_sched = '{0, 47, 11};
    idle_pct = 0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    operation_i <= OP_PUSH;
    key_in_i <= '0;
    item_in_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty heap, extremes and ties at the reset capacity
    issue(OP_POP, '1, '1);              // pop on empty heap
    issue(OP_UNUSED, '0, '0);           // no-op on empty heap
    issue(OP_PUSH, '1, '1);
    issue(OP_PUSH, '0, '1);
    issue(OP_PUSH, '0, '0);             // same key, lower item wins
    issue(OP_PUSH, '0, 32'd1);
    issue(OP_PUSH, '1, '0);
    issue(OP_UNUSED, '1, '1);           // no-op reports the minimum
    repeat (6) issue(OP_POP, '0, '0);   // last one hits the empty heap
    issue(OP_PUSH, 64'h8000_0000_0000_0000, 32'h8000_0000);
    issue(OP_PUSH, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff);
    issue(OP_CLEAR, '1, '1);
    issue(OP_POP, '0, '0);              // empty again after clear

    // zero limit: every push refused
    set_capacity(11'd0);
    issue(OP_PUSH, 64'd5, 32'd5);
    // limit of two, then lowered below the count
    set_capacity(11'd2);
    repeat (3) issue(OP_PUSH, pick_key(), pick_item());
    set_capacity(11'd1);
    issue(OP_PUSH, 64'd1, 32'd1);       // refused, count above limit
    issue(OP_POP, '0, '0);
    issue(OP_PUSH, 64'd2, 32'd2);       // still refused, count equals limit
    issue(OP_POP, '0, '0);
    issue(OP_PUSH, 64'd3, 32'd3);       // fits again

    // random phases over several capacities and sender idle rates;
    // the heap is kept across phases so some limits drop below the count
    for (int p = 0; p < 8; p++) begin
      set_capacity(cap_sched[p]);
      idle_pct = idle_sched[p % 3];
      random_phase(PHASE_ITEMS, 55);
    end

    // grow a deep heap with the limit above the depth, then let pops
    // sink through every level
    set_capacity(11'd2047);
    idle_pct = 11;
    issue(OP_CLEAR, '0, '0);
    idle_pct = 0;
    for (int i = 0; i < FILL_ITEMS; i++) issue(OP_PUSH, pick_key(), pick_item());
    set_capacity(11'd1024);
    issue(OP_PUSH, pick_key(), pick_item());
    idle_pct = 47;
    random_phase(60, 10);
    // limit far below the count
    set_capacity(11'd5);
    idle_pct = 11;
    random_phase(30, 30);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("quaternary_min_heap_top_tb OK");
    end else begin
      $display("quaternary_min_heap_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("quaternary_min_heap_top_tb NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/qmh_pkg.sv
rtl/qmh_ram.sv
rtl/quaternary_min_heap_top.sv
tb/quaternary_min_heap_checker.sv
tb/quaternary_min_heap_top_tb.sv
